// ===== rtl/integral_image_box_centroid_defines.svh =====
// Assertion macros shared by the summed-area centroid block.
`ifndef INTEGRAL_IMAGE_BOX_CENTROID_DEFINES_SVH
`define INTEGRAL_IMAGE_BOX_CENTROID_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IIBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IIBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/iibc_pkg.sv =====
// Package with types, constants and helpers of the summed-area centroid block.
`default_nettype none
package iibc_pkg;

    // Image limits and derived table geometry.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int TSTRIDE    = MAX_WIDTH + 1;
    localparam int TDEPTH     = TSTRIDE * (MAX_HEIGHT + 1);
    localparam int ADDR_W     = $clog2(TDEPTH);
    localparam int TCOL_W     = $clog2(MAX_WIDTH + 1);
    localparam int TROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int LCOL_W     = $clog2(MAX_WIDTH);
    localparam int LROW_W     = $clog2(MAX_HEIGHT);

    // Fixed field widths.
    localparam int CFG_W   = 10;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 9;
    localparam int RAD_W   = 6;
    localparam int BW_W    = 26;
    localparam int CEN_W   = 17;
    localparam int FRAC_W  = 8;
    localparam int SW_W    = 27;
    localparam int SXY_W   = 36;
    localparam int TAB_W   = SW_W + 2 * SXY_W;
    localparam int PWX_W   = PIX_W + LCOL_W;
    localparam int PWY_W   = PIX_W + LROW_W;
    localparam int NUM_W   = SXY_W + FRAC_W;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int XCMP_W  = ((TCOL_W > POS_W) ? TCOL_W : POS_W) + 1;
    localparam int YCMP_W  = ((TROW_W > POS_W) ? TROW_W : POS_W) + 1;

    // Queue depths.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd512;

    // Request operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_weight;
        logic [POS_W-1:0] query_x;
        logic [POS_W-1:0] query_y;
        logic [RAD_W-1:0] box_radius;
    } item_t;

    typedef struct packed {
        logic [BW_W-1:0]  box_weight;
        logic [CEN_W-1:0] centroid_x;
        logic [CEN_W-1:0] centroid_y;
        logic             no_edge;
        logic             query_invalid;
    } result_t;

    // Classified request passed from front to back.
    typedef struct packed {
        logic              op;
        logic              invalid;
        logic              row_start;
        logic [PIX_W-1:0]  pw;
        logic [PWX_W-1:0]  pwx;
        logic [PWY_W-1:0]  pwy;
        logic [LCOL_W-1:0] lcol;
        logic [LROW_W-1:0] lrow;
        logic [POS_W-1:0]  qx;
        logic [POS_W-1:0]  qy;
        logic [TCOL_W-1:0] x0;
        logic [TCOL_W-1:0] x1;
        logic [TROW_W-1:0] y0;
        logic [TROW_W-1:0] y1;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    // Linear table address of entry (col, row).
    function automatic logic [ADDR_W-1:0] tab_addr(input logic [TCOL_W-1:0] col,
                                                  input logic [TROW_W-1:0] row);
        tab_addr = ADDR_W'(row) * ADDR_W'(TSTRIDE) + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/iibc_front.sv =====
// Front end: configuration, load position tracking and query clamping.
`default_nettype none
module iibc_front (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    push,
    input  wire  iibc_pkg::item_t                  item,
    input  wire                                    cfg_we,
    input  wire  [iibc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [iibc_pkg::CFG_W-1:0]             cfg_data,
    input  wire                                    cmd_full,
    output logic                                   cmd_push,
    output iibc_pkg::cmd_t                         cmd
);

    logic [iibc_pkg::CFG_W-1:0]  width_reg;
    logic [iibc_pkg::CFG_W-1:0]  height_reg;
    logic [iibc_pkg::LCOL_W-1:0] col_reg, col_next;
    logic [iibc_pkg::LROW_W-1:0] row_reg, row_next;
    logic [iibc_pkg::TCOL_W-1:0] w_eff;
    logic [iibc_pkg::TROW_W-1:0] h_eff;
    logic [iibc_pkg::XCMP_W-1:0] span_x, gx, lim_x;
    logic [iibc_pkg::YCMP_W-1:0] span_y, gy, lim_y;
    logic [iibc_pkg::XCMP_W-1:0] rad_x;
    logic [iibc_pkg::YCMP_W-1:0] rad_y;
    logic                        accept;

    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    // Effective image size, saturated to the table limits.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = iibc_pkg::TCOL_W'(1);
        else if (32'(width_reg) > 32'(iibc_pkg::MAX_WIDTH))
            w_eff = iibc_pkg::TCOL_W'(iibc_pkg::MAX_WIDTH);
        else
            w_eff = iibc_pkg::TCOL_W'(width_reg);
        if (height_reg == '0)
            h_eff = iibc_pkg::TROW_W'(1);
        else if (32'(height_reg) > 32'(iibc_pkg::MAX_HEIGHT))
            h_eff = iibc_pkg::TROW_W'(iibc_pkg::MAX_HEIGHT);
        else
            h_eff = iibc_pkg::TROW_W'(height_reg);
    end

    // Next load position in row-major order with wrap.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && item.op == iibc_pkg::OP_LOAD)
        begin
            if (iibc_pkg::TCOL_W'(col_reg) + iibc_pkg::TCOL_W'(1) >= w_eff)
            begin
                col_next = '0;
                if (iibc_pkg::TROW_W'(row_reg) + iibc_pkg::TROW_W'(1) >= h_eff)
                    row_next = '0;
                else
                    row_next = row_reg + iibc_pkg::LROW_W'(1);
            end
            else
                col_next = col_reg + iibc_pkg::LCOL_W'(1);
        end
    end

    // Configuration registers; any write restarts loading at the origin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= iibc_pkg::CFG_SIZE_RESET;
            height_reg <= iibc_pkg::CFG_SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iibc_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                iibc_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
            endcase
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Query check and centre clamping into the image.
    always_comb
    begin
        rad_x  = iibc_pkg::XCMP_W'(item.box_radius);
        rad_y  = iibc_pkg::YCMP_W'(item.box_radius);
        span_x = (rad_x << 1) + iibc_pkg::XCMP_W'(1);
        span_y = (rad_y << 1) + iibc_pkg::YCMP_W'(1);
        lim_x  = iibc_pkg::XCMP_W'(w_eff) - rad_x - iibc_pkg::XCMP_W'(1);
        lim_y  = iibc_pkg::YCMP_W'(h_eff) - rad_y - iibc_pkg::YCMP_W'(1);
        gx = (iibc_pkg::XCMP_W'(item.query_x) < rad_x) ? rad_x
                                                       : iibc_pkg::XCMP_W'(item.query_x);
        gy = (iibc_pkg::YCMP_W'(item.query_y) < rad_y) ? rad_y
                                                       : iibc_pkg::YCMP_W'(item.query_y);
        if (gx > lim_x)
            gx = lim_x;
        if (gy > lim_y)
            gy = lim_y;
    end

    // Classified request for the back end.
    always_comb
    begin
        cmd.op        = item.op;
        cmd.invalid   = (span_x > iibc_pkg::XCMP_W'(w_eff)) ||
                        (span_y > iibc_pkg::YCMP_W'(h_eff));
        cmd.row_start = (col_reg == '0);
        cmd.pw        = item.pixel_weight;
        cmd.pwx       = iibc_pkg::PWX_W'(item.pixel_weight) * iibc_pkg::PWX_W'(col_reg);
        cmd.pwy       = iibc_pkg::PWY_W'(item.pixel_weight) * iibc_pkg::PWY_W'(row_reg);
        cmd.lcol      = col_reg;
        cmd.lrow      = row_reg;
        cmd.qx        = item.query_x;
        cmd.qy        = item.query_y;
        cmd.x0        = iibc_pkg::TCOL_W'(gx - rad_x);
        cmd.x1        = iibc_pkg::TCOL_W'(gx + rad_x + iibc_pkg::XCMP_W'(1));
        cmd.y0        = iibc_pkg::TROW_W'(gy - rad_y);
        cmd.y1        = iibc_pkg::TROW_W'(gy + rad_y + iibc_pkg::YCMP_W'(1));
    end

endmodule
`default_nettype wire

// ===== rtl/iibc_cmd_fifo.sv =====
// Request queue between the front end and the back end.
`default_nettype none
module iibc_cmd_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_en,
    input  wire iibc_pkg::cmd_t wr_data,
    output logic                full,
    input  wire                 rd_en,
    output iibc_pkg::cmd_t      rd_data,
    output logic                empty
);

    iibc_pkg::cmd_t                 slot_reg [iibc_pkg::CMD_DEPTH];
    logic [iibc_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [iibc_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [iibc_pkg::CMD_PTR_W:0]   count_reg;

    assign full    = (count_reg == (iibc_pkg::CMD_PTR_W + 1)'(iibc_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + iibc_pkg::CMD_PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + iibc_pkg::CMD_PTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (iibc_pkg::CMD_PTR_W + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (iibc_pkg::CMD_PTR_W + 1)'(1);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== rtl/iibc_res_queue.sv =====
// Result queue that holds finished query results until they are taken.
`default_nettype none
module iibc_res_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  wire iibc_pkg::result_t wr_data,
    output logic                   full,
    input  wire                    rd_en,
    output iibc_pkg::result_t      rd_data,
    output logic                   empty
);

    iibc_pkg::result_t              slot_reg [iibc_pkg::RES_DEPTH];
    logic [iibc_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [iibc_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [iibc_pkg::RES_PTR_W:0]   count_reg;

    assign full    = (count_reg == (iibc_pkg::RES_PTR_W + 1)'(iibc_pkg::RES_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + iibc_pkg::RES_PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + iibc_pkg::RES_PTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (iibc_pkg::RES_PTR_W + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (iibc_pkg::RES_PTR_W + 1)'(1);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== rtl/iibc_back.sv =====
// Back end: summed-area table memory, load pipeline, corner reads and division.
`default_nettype none
module iibc_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_empty,
    input  wire iibc_pkg::cmd_t cmd,
    output logic                cmd_pop,
    input  wire                 res_full,
    output logic                res_push,
    output iibc_pkg::result_t   res
);

    localparam int SW_W  = iibc_pkg::SW_W;
    localparam int SXY_W = iibc_pkg::SXY_W;
    localparam int BW_W  = iibc_pkg::BW_W;
    localparam int NUM_W = iibc_pkg::NUM_W;
    localparam int CEN_W = iibc_pkg::CEN_W;

    iibc_pkg::bk_state_t state_reg, state_next;

    // Table memory, one word holds all three channels.
    logic [iibc_pkg::TAB_W-1:0]  tab_mem [iibc_pkg::TDEPTH];
    logic [iibc_pkg::TAB_W-1:0]  rd_data_reg;
    logic                        rd_en;
    logic [iibc_pkg::ADDR_W-1:0] rd_addr;
    logic                        rd_zero, rd_zero_reg;
    logic                        rd_neg, rd_neg_reg;

    // Load pipeline stage that adds and writes back.
    logic                        ld_issue;
    logic                        s1_valid_reg;
    logic [iibc_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [iibc_pkg::PIX_W-1:0]  s1_pw_reg;
    logic [iibc_pkg::PWX_W-1:0]  s1_pwx_reg;
    logic [iibc_pkg::PWY_W-1:0]  s1_pwy_reg;
    logic                        s1_start_reg;
    logic                        s1_fwd_reg, fwd_next;
    logic [SW_W-1:0]             racc_w_reg, nacc_w, u_w, t_w;
    logic [SXY_W-1:0]            racc_x_reg, nacc_x, u_x, t_x;
    logic [SXY_W-1:0]            racc_y_reg, nacc_y, u_y, t_y;
    logic [SW_W-1:0]             fwd_w_reg;
    logic [SXY_W-1:0]            fwd_x_reg, fwd_y_reg;
    logic [SW_W-1:0]             mem_w;
    logic [SXY_W-1:0]            mem_x, mem_y;

    // Query datapath.
    logic                        q_start;
    iibc_pkg::cmd_t              q_reg;
    logic [2:0]                  cnt_reg;
    logic [SW_W-1:0]             acc_w_reg;
    logic [SXY_W-1:0]            acc_x_reg, acc_y_reg;
    logic [BW_W-1:0]             bw;
    logic [BW_W-1:0]             rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic [NUM_W-1:0]            num_x_reg, num_y_reg;
    logic [CEN_W-1:0]            quo_x_reg, quo_y_reg, quo_x_next, quo_y_next;
    logic [iibc_pkg::DCNT_W-1:0] dcnt_reg;
    logic [BW_W:0]               trial_x, trial_y;
    logic                        ge_x, ge_y;
    iibc_pkg::result_t           res_reg;

    assign mem_w = rd_data_reg[iibc_pkg::TAB_W-1 -: SW_W];
    assign mem_x = rd_data_reg[2*SXY_W-1 -: SXY_W];
    assign mem_y = rd_data_reg[SXY_W-1:0];
    assign bw    = acc_w_reg[BW_W-1:0];
    assign res   = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iibc_pkg::BK_IDLE:
                if (q_start)
                    state_next = cmd.invalid ? iibc_pkg::BK_OUT : iibc_pkg::BK_READ;
            iibc_pkg::BK_READ:
                if (cnt_reg == 3'd4)
                    state_next = iibc_pkg::BK_CHECK;
            iibc_pkg::BK_CHECK:
                state_next = (bw == '0) ? iibc_pkg::BK_OUT : iibc_pkg::BK_DIV;
            iibc_pkg::BK_DIV:
                if (dcnt_reg == iibc_pkg::DCNT_W'(NUM_W - 1))
                    state_next = iibc_pkg::BK_OUT;
            iibc_pkg::BK_OUT:
                if (!res_full)
                    state_next = iibc_pkg::BK_IDLE;
            default:
                state_next = iibc_pkg::BK_IDLE;
        endcase
    end

    // Outputs: queue pops, memory read requests and result push.
    always_comb
    begin
        cmd_pop  = 1'b0;
        ld_issue = 1'b0;
        q_start  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        rd_zero  = 1'b0;
        rd_neg   = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            iibc_pkg::BK_IDLE:
                if (!cmd_empty)
                begin
                    if (cmd.op == iibc_pkg::OP_LOAD)
                    begin
                        cmd_pop  = 1'b1;
                        ld_issue = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = iibc_pkg::tab_addr(
                            iibc_pkg::TCOL_W'(cmd.lcol) + iibc_pkg::TCOL_W'(1),
                            iibc_pkg::TROW_W'(cmd.lrow));
                        rd_zero  = (cmd.lrow == '0);
                    end
                    else if (!s1_valid_reg)
                    begin
                        cmd_pop = 1'b1;
                        q_start = 1'b1;
                    end
                end
            iibc_pkg::BK_READ:
                if (!cnt_reg[2])
                begin
                    rd_en = 1'b1;
                    case (cnt_reg[1:0])
                        2'd0:
                        begin
                            rd_addr = iibc_pkg::tab_addr(q_reg.x1, q_reg.y1);
                            rd_zero = (q_reg.x1 == '0) || (q_reg.y1 == '0);
                        end
                        2'd1:
                        begin
                            rd_addr = iibc_pkg::tab_addr(q_reg.x0, q_reg.y1);
                            rd_zero = (q_reg.x0 == '0) || (q_reg.y1 == '0);
                            rd_neg  = 1'b1;
                        end
                        2'd2:
                        begin
                            rd_addr = iibc_pkg::tab_addr(q_reg.x1, q_reg.y0);
                            rd_zero = (q_reg.x1 == '0) || (q_reg.y0 == '0);
                            rd_neg  = 1'b1;
                        end
                        default:
                        begin
                            rd_addr = iibc_pkg::tab_addr(q_reg.x0, q_reg.y0);
                            rd_zero = (q_reg.x0 == '0) || (q_reg.y0 == '0);
                        end
                    endcase
                end
            iibc_pkg::BK_OUT:
                res_push = !res_full;
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Load arithmetic: row prefix sum plus the entry one row above.
    always_comb
    begin
        u_w    = s1_fwd_reg ? fwd_w_reg : (rd_zero_reg ? '0 : mem_w);
        u_x    = s1_fwd_reg ? fwd_x_reg : (rd_zero_reg ? '0 : mem_x);
        u_y    = s1_fwd_reg ? fwd_y_reg : (rd_zero_reg ? '0 : mem_y);
        nacc_w = (s1_start_reg ? '0 : racc_w_reg) + SW_W'(s1_pw_reg);
        nacc_x = (s1_start_reg ? '0 : racc_x_reg) + SXY_W'(s1_pwx_reg);
        nacc_y = (s1_start_reg ? '0 : racc_y_reg) + SXY_W'(s1_pwy_reg);
        t_w    = nacc_w + u_w;
        t_x    = nacc_x + u_x;
        t_y    = nacc_y + u_y;
        fwd_next = s1_valid_reg && ld_issue && (rd_addr == s1_addr_reg);
    end

    // One restoring division step for both centroid axes.
    always_comb
    begin
        trial_x    = {rem_x_reg, num_x_reg[NUM_W-1]};
        trial_y    = {rem_y_reg, num_y_reg[NUM_W-1]};
        ge_x       = (trial_x >= {1'b0, bw});
        ge_y       = (trial_y >= {1'b0, bw});
        rem_x_next = ge_x ? BW_W'(trial_x - {1'b0, bw}) : trial_x[BW_W-1:0];
        rem_y_next = ge_y ? BW_W'(trial_y - {1'b0, bw}) : trial_y[BW_W-1:0];
        quo_x_next = {quo_x_reg[CEN_W-2:0], ge_x};
        quo_y_next = {quo_y_reg[CEN_W-2:0], ge_y};
    end

    // Table memory: one write port from the load stage, one registered read port.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            tab_mem[s1_addr_reg] <= {t_w, t_x, t_y};
        if (rd_en)
            rd_data_reg <= tab_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= iibc_pkg::BK_IDLE;
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            dcnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= ld_issue;
            if (q_start)
                cnt_reg <= '0;
            else if (state_reg == iibc_pkg::BK_READ)
                cnt_reg <= cnt_reg + 3'd1;
            if (state_reg == iibc_pkg::BK_CHECK)
                dcnt_reg <= '0;
            else if (state_reg == iibc_pkg::BK_DIV)
                dcnt_reg <= dcnt_reg + iibc_pkg::DCNT_W'(1);
        end
    end

    // Load stage payload and row accumulators.
    always_ff @(posedge clk)
    begin
        rd_zero_reg  <= rd_zero;
        rd_neg_reg   <= rd_neg;
        s1_addr_reg  <= iibc_pkg::tab_addr(
            iibc_pkg::TCOL_W'(cmd.lcol) + iibc_pkg::TCOL_W'(1),
            iibc_pkg::TROW_W'(cmd.lrow) + iibc_pkg::TROW_W'(1));
        s1_pw_reg    <= cmd.pw;
        s1_pwx_reg   <= cmd.pwx;
        s1_pwy_reg   <= cmd.pwy;
        s1_start_reg <= cmd.row_start;
        s1_fwd_reg   <= fwd_next;
        fwd_w_reg    <= t_w;
        fwd_x_reg    <= t_x;
        fwd_y_reg    <= t_y;
        if (s1_valid_reg)
        begin
            racc_w_reg <= nacc_w;
            racc_x_reg <= nacc_x;
            racc_y_reg <= nacc_y;
        end
    end

    // Query payload: corner sums, divider and result.
    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            q_reg     <= cmd;
            acc_w_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            res_reg   <= '0;
            res_reg.query_invalid <= cmd.invalid;
        end
        if (state_reg == iibc_pkg::BK_READ && cnt_reg != '0)
        begin
            if (rd_neg_reg)
            begin
                acc_w_reg <= acc_w_reg - (rd_zero_reg ? '0 : mem_w);
                acc_x_reg <= acc_x_reg - (rd_zero_reg ? '0 : mem_x);
                acc_y_reg <= acc_y_reg - (rd_zero_reg ? '0 : mem_y);
            end
            else
            begin
                acc_w_reg <= acc_w_reg + (rd_zero_reg ? '0 : mem_w);
                acc_x_reg <= acc_x_reg + (rd_zero_reg ? '0 : mem_x);
                acc_y_reg <= acc_y_reg + (rd_zero_reg ? '0 : mem_y);
            end
        end
        if (state_reg == iibc_pkg::BK_CHECK)
        begin
            num_x_reg <= {acc_x_reg, iibc_pkg::FRAC_W'(0)};
            num_y_reg <= {acc_y_reg, iibc_pkg::FRAC_W'(0)};
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            quo_x_reg <= '0;
            quo_y_reg <= '0;
            if (bw == '0)
            begin
                res_reg.box_weight <= '0;
                res_reg.centroid_x <= CEN_W'({q_reg.qx, iibc_pkg::FRAC_W'(0)});
                res_reg.centroid_y <= CEN_W'({q_reg.qy, iibc_pkg::FRAC_W'(0)});
                res_reg.no_edge    <= 1'b1;
            end
        end
        if (state_reg == iibc_pkg::BK_DIV)
        begin
            num_x_reg <= num_x_reg << 1;
            num_y_reg <= num_y_reg << 1;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            if (dcnt_reg == iibc_pkg::DCNT_W'(NUM_W - 1))
            begin
                res_reg.box_weight <= bw;
                res_reg.centroid_x <= quo_x_next;
                res_reg.centroid_y <= quo_y_next;
                res_reg.no_edge    <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/integral_image_box_centroid.sv =====
// Top level of the summed-area table box centroid block.
// Loads: one request per cycle while the back end is idle, read at the pop cycle and added and written the next.
// Query steps once an idle back end takes the request: pop, four corner reads, check,
// 44 divider steps for both axes in parallel, push.
// A zero-weight box skips the divider; a radius too large skips reads and divider; a query waits behind a load write.
// Reset sets both sizes to 512 and clears control state; row 0 and column 0 read as zero.
`default_nettype none
`include "integral_image_box_centroid_defines.svh"
module integral_image_box_centroid (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                push,
    output logic                               full,
    input  wire  iibc_pkg::item_t              item,
    output logic                               empty,
    input  wire                                pop,
    output iibc_pkg::result_t                  result,
    input  wire                                cfg_we,
    input  wire  [iibc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [iibc_pkg::CFG_W-1:0]         cfg_data
);

    iibc_pkg::cmd_t    f_cmd, b_cmd;
    iibc_pkg::result_t b_res;
    logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic              res_push, res_full, res_pop;

    assign full    = cmd_full;
    assign res_pop = pop && !empty;

    // Front end classifies each request.
    iibc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (f_cmd)
    );

    // Queue decouples front and back.
    iibc_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (f_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (b_cmd),
        .empty   (cmd_empty)
    );

    // Back end executes loads and queries.
    iibc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (b_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (b_res)
    );

    // Finished results wait here.
    iibc_res_queue u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (b_res),
        .full    (res_full),
        .rd_en   (res_pop),
        .rd_data (result),
        .empty   (empty)
    );

    // Queue discipline and result consistency.
    `IIBC_ASSERT_NOW(a_cmd_pop_nonempty, cmd_pop, !cmd_empty, "request popped from empty queue")
    `IIBC_ASSERT_NOW(a_res_push_room, res_push, !res_full, "result pushed into full queue")
    `IIBC_ASSERT_NOW(a_invalid_clean, !empty && result.query_invalid, result.box_weight == '0 && !result.no_edge, "invalid query result carries data")
    `IIBC_ASSERT_NOW(a_no_edge_zero, !empty && result.no_edge, result.box_weight == '0 && !result.query_invalid, "no-edge result with nonzero weight")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the summed-area table box centroid block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int STRIDE = iibc_pkg::MAX_WIDTH + 1;
    localparam int DEPTH  = STRIDE * (iibc_pkg::MAX_HEIGHT + 1);

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    iibc_pkg::item_t item;
    logic empty;
    logic pop;
    iibc_pkg::result_t result;
    logic cfg_we;
    logic [iibc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [iibc_pkg::CFG_W-1:0] cfg_data;

    integral_image_box_centroid uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: the three running-sum tables and which entries hold data.
    bit [iibc_pkg::SW_W-1:0]  sum_w  [0:DEPTH-1];
    bit [iibc_pkg::SXY_W-1:0] sum_wx [0:DEPTH-1];
    bit [iibc_pkg::SXY_W-1:0] sum_wy [0:DEPTH-1];
    bit                       filled [0:DEPTH-1];
    int                       load_col;
    int                       load_row;
    int                       width_reg;
    int                       height_reg;

    iibc_pkg::result_t pending_results[$];
    int                mismatches;
    bit                idle_on;
    int                hold_long;
    int                stall_left;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    function automatic int eff_width();
        return (width_reg < 1) ? 1 :
            ((width_reg > iibc_pkg::MAX_WIDTH) ? iibc_pkg::MAX_WIDTH : width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg < 1) ? 1 :
            ((height_reg > iibc_pkg::MAX_HEIGHT) ? iibc_pkg::MAX_HEIGHT : height_reg);
    endfunction

    function automatic int ix(input int col, input int row);
        return row * STRIDE + col;
    endfunction

    // Clamp the box into the image; the caller ensures the box fits.
    function automatic void clamp_box(input int qx, input int qy, input int r,
                                      output int x0, output int x1,
                                      output int y0, output int y1);
        int gx;
        int gy;
        gx = (qx < r) ? r : qx;
        gy = (qy < r) ? r : qy;
        if (gx > eff_width() - r - 1)
            gx = eff_width() - r - 1;
        if (gy > eff_height() - r - 1)
            gy = eff_height() - r - 1;
        x0 = gx - r;
        x1 = gx + r + 1;
        y0 = gy - r;
        y1 = gy + r + 1;
    endfunction

    function automatic bit box_fits(input int r);
        return (2 * r + 1 <= eff_width()) && (2 * r + 1 <= eff_height());
    endfunction

    // True when every corner that the query reads holds loaded data.
    function automatic bit corners_filled(input int qx, input int qy, input int r);
        int x0;
        int x1;
        int y0;
        int y1;
        if (!box_fits(r))
            return 1'b1;
        clamp_box(qx, qy, r, x0, x1, y0, y1);
        return filled[ix(x1, y1)] && filled[ix(x0, y1)] && filled[ix(x1, y0)]
            && filled[ix(x0, y0)];
    endfunction

    // Apply one accepted request to the tables; returns 1 when a result follows.
    function automatic bit predict_centroid(input iibc_pkg::item_t req,
                                            output iibc_pkg::result_t res);
        int x0;
        int x1;
        int y0;
        int y1;
        int t;
        bit [iibc_pkg::SW_W-1:0]  bw27;
        bit [iibc_pkg::SXY_W-1:0] sx;
        bit [iibc_pkg::SXY_W-1:0] sy;
        bit [iibc_pkg::BW_W-1:0]  bw;
        bit [iibc_pkg::NUM_W-1:0] num_x;
        bit [iibc_pkg::NUM_W-1:0] num_y;
        res = '0;
        if (req.op == iibc_pkg::OP_LOAD)
        begin
            t = ix(load_col + 1, load_row + 1);
            sum_w[t] = iibc_pkg::SW_W'(req.pixel_weight + sum_w[ix(load_col, load_row + 1)]
                + sum_w[ix(load_col + 1, load_row)] - sum_w[ix(load_col, load_row)]);
            sum_wx[t] = iibc_pkg::SXY_W'(64'(req.pixel_weight) * load_col
                + sum_wx[ix(load_col, load_row + 1)] + sum_wx[ix(load_col + 1, load_row)]
                - sum_wx[ix(load_col, load_row)]);
            sum_wy[t] = iibc_pkg::SXY_W'(64'(req.pixel_weight) * load_row
                + sum_wy[ix(load_col, load_row + 1)] + sum_wy[ix(load_col + 1, load_row)]
                - sum_wy[ix(load_col, load_row)]);
            filled[t] = 1'b1;
            load_col++;
            if (load_col >= eff_width())
            begin
                load_col = 0;
                load_row++;
                if (load_row >= eff_height())
                    load_row = 0;
            end
            return 1'b0;
        end
        if (!box_fits(req.box_radius))
        begin
            res.query_invalid = 1'b1;
            return 1'b1;
        end
        clamp_box(req.query_x, req.query_y, req.box_radius, x0, x1, y0, y1);
        bw27 = sum_w[ix(x1, y1)] - sum_w[ix(x0, y1)] - sum_w[ix(x1, y0)] + sum_w[ix(x0, y0)];
        sx = sum_wx[ix(x1, y1)] - sum_wx[ix(x0, y1)] - sum_wx[ix(x1, y0)]
            + sum_wx[ix(x0, y0)];
        sy = sum_wy[ix(x1, y1)] - sum_wy[ix(x0, y1)] - sum_wy[ix(x1, y0)]
            + sum_wy[ix(x0, y0)];
        bw = bw27[iibc_pkg::BW_W-1:0];
        res.box_weight = bw;
        if (bw == 0)
        begin
            res.centroid_x = iibc_pkg::CEN_W'({req.query_x, 8'h00});
            res.centroid_y = iibc_pkg::CEN_W'({req.query_y, 8'h00});
            res.no_edge = 1'b1;
        end
        else
        begin
            num_x = {sx, 8'h00};
            num_y = {sy, 8'h00};
            res.centroid_x = iibc_pkg::CEN_W'(num_x / bw);
            res.centroid_y = iibc_pkg::CEN_W'(num_y / bw);
        end
        return 1'b1;
    endfunction

    // Request with random filler in the fields that its operation ignores.
    function automatic iibc_pkg::item_t random_item();
        iibc_pkg::item_t req;
        req.op = iibc_pkg::OP_LOAD;
        req.pixel_weight = iibc_pkg::PIX_W'($urandom());
        req.query_x = iibc_pkg::POS_W'($urandom());
        req.query_y = iibc_pkg::POS_W'($urandom());
        req.box_radius = iibc_pkg::RAD_W'($urandom());
        return req;
    endfunction

    // Offer one request and wait until the block takes it.
    task automatic send_request(input iibc_pkg::item_t req);
        iibc_pkg::result_t res;
        @(negedge clk);
        item <= req;
        push <= 1'b1;
        do @(posedge clk); while (full);
        if (predict_centroid(req, res))
            pending_results = {pending_results, res};
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    task automatic send_load(input int weight);
        iibc_pkg::item_t req;
        req = random_item();
        req.op = iibc_pkg::OP_LOAD;
        req.pixel_weight = iibc_pkg::PIX_W'(weight);
        send_request(req);
    endtask

    task automatic send_query(input int qx, input int qy, input int r);
        iibc_pkg::item_t req;
        req = random_item();
        req.op = iibc_pkg::OP_QUERY;
        req.query_x = iibc_pkg::POS_W'(qx);
        req.query_y = iibc_pkg::POS_W'(qy);
        req.box_radius = iibc_pkg::RAD_W'(r);
        send_request(req);
    endtask

    // Pause the sender until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Write one size register; loading restarts at the first pixel.
    task automatic write_size(input logic [iibc_pkg::CFG_IDX_W-1:0] idx, input int value);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= iibc_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == iibc_pkg::CFG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        load_col = 0;
        load_row = 0;
    endtask

    // Random query whose corners are all loaded; falls back to a load.
    task automatic random_query();
        int qx;
        int qy;
        int r;
        int rmax;
        int tries;
        rmax = ((eff_width() < eff_height() ? eff_width() : eff_height()) - 1) / 2;
        if (rmax > 63)
            rmax = 63;
        for (tries = 0; tries < 12; tries++)
        begin
            qx = $urandom_range(0, 511);
            qy = $urandom_range(0, 511);
            r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, rmax);
            if (corners_filled(qx, qy, r))
            begin
                send_query(qx, qy, r);
                return;
            end
        end
        send_load($urandom_range(0, 255));
    endtask

    // One image size: stream the pixels with queries mixed in, then more queries.
    task automatic run_image_phase(input int wval, input int hval, input int extra);
        int pixels;
        int n;
        write_size(iibc_pkg::CFG_IMAGE_WIDTH, wval);
        write_size(iibc_pkg::CFG_IMAGE_HEIGHT, hval);
        pixels = eff_width() * eff_height();
        for (n = 0; n < pixels; n++)
        begin
            send_load(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0)
                random_query();
        end
        for (n = 0; n < extra; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_load($urandom_range(0, 255));
            else
                random_query();
        end
    endtask

    // Directed: reset size, partial first row and single-pixel queries on it.
    task automatic test_reset_size();
        int n;
        for (n = 0; n < 12; n++)
            send_load(n == 0 ? 255 : n * 20);
        send_query(0, 0, 0);
        send_query(5, 0, 0);
        send_query(11, 0, 0);
    endtask

    // Directed 8x8 image: a zero half and a full-weight half.
    task automatic test_small_image();
        int n;
        write_size(iibc_pkg::CFG_IMAGE_WIDTH, 8);
        write_size(iibc_pkg::CFG_IMAGE_HEIGHT, 8);
        for (n = 0; n < 64; n++)
            send_load(n < 32 ? 0 : 255);
        send_query(0, 0, 0);
        send_query(511, 0, 0);
        send_query(511, 511, 0);
        send_query(3, 3, 3);
        send_query(0, 511, 1);
        send_query(4, 4, 4);
        send_query(4, 4, 63);
    endtask

    // The receiver stalls long while queries keep coming, so the block fills.
    task automatic test_backpressure();
        int n;
        hold_long = 600;
        for (n = 0; n < 14; n++)
            send_query($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 3));
        wait_drained();
    endtask

    // Random small images and sizes that saturate at both ends.
    task automatic test_random_sizes();
        int p;
        for (p = 0; p < 4; p++)
            run_image_phase($urandom_range(1, 14), $urandom_range(1, 14), 20);
        run_image_phase(0, 3, 20);
        run_image_phase(1023, 1, 20);
        run_image_phase(2, 0, 20);
    endtask

    // Final stretch with no idling on either side.
    task automatic test_full_rate();
        wait_drained();
        idle_on = 1'b0;
        run_image_phase(12, 8, 40);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        iibc_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.box_weight !== want.box_weight
                    || result.centroid_x !== want.centroid_x
                    || result.centroid_y !== want.centroid_y
                    || result.no_edge !== want.no_edge
                    || result.query_invalid !== want.query_invalid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // Receiver side with random stalls and the long hold.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_long > 0)
            begin
                pop <= 1'b0;
                hold_long--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Run time limit.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int n;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_on = 1'b1;
        hold_long = 0;
        stall_left = 0;
        width_reg = iibc_pkg::CFG_SIZE_RESET;
        height_reg = iibc_pkg::CFG_SIZE_RESET;
        load_col = 0;
        load_row = 0;
        for (n = 0; n < DEPTH; n++)
            filled[n] = (n < STRIDE) || (n % STRIDE == 0);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_size();
        test_small_image();
        test_backpressure();
        test_random_sizes();
        test_full_rate();

        wait_drained();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
